[rtl/hsk_pkg.sv]
// Package for the heapsort key/payload engine.
// Holds the stored entry layout, the memory control struct and the sorter state type.
// No dependencies.
`timescale 1ns / 1ps

package hsk_pkg;

  // Width of the sort key and of the position payload.
  localparam int KEY_W = 64;
  localparam int POS_W = 16;

  // One stored entry: the key in the upper bits, the payload below it.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Enables of the single read port and the single write port of the entry memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Sequencer states of the sorter.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_NODE,
    ST_HOLD_CAP,
    ST_SIFT_CHK,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SIFT_CMP,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_EX_SWAP
  } sort_state_t;

endpackage

[rtl/hsk_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module hsk_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hsk_sorter.sv]
// Heapsort sequencer that works in place on the entry memory.
// Depends on hsk_pkg; drives the memory ports while it is busy.
`timescale 1ns / 1ps

module hsk_sorter #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0] start_size,
  output logic                             busy,
  output hsk_pkg::mem_ctl_t                mem_ctl,
  output logic [$clog2(MAX_ENTRIES)-1:0]   wr_addr,
  output hsk_pkg::entry_t                  wr_data,
  output logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
  input  hsk_pkg::entry_t                  rd_data
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = ADDR_W + 1;

  hsk_pkg::sort_state_t state;
  hsk_pkg::sort_state_t state_next;
  hsk_pkg::sort_state_t after_sift;

  logic              build;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  size;
  logic [ADDR_W-1:0] node;
  logic [ADDR_W-1:0] pick;
  hsk_pkg::entry_t   hold;
  hsk_pkg::entry_t   best;

  logic [CNT_W-1:0] k_dec;
  logic [CNT_W-1:0] size_dec;
  logic [IDX_W-1:0] size_w;
  logic [IDX_W-1:0] child_w;
  logic [IDX_W-1:0] right_w;
  logic             no_child;
  logic             has_right;
  logic             sink;
  logic             sift_end;

  // Index arithmetic of the current sift step.
  assign k_dec     = k - CNT_W'(1);
  assign size_dec  = size - CNT_W'(1);
  assign size_w    = IDX_W'(size);
  assign child_w   = {node, 1'b1};
  assign right_w   = IDX_W'(pick) + IDX_W'(1);
  assign no_child  = (child_w >= size_w);
  assign has_right = (right_w < size_w);
  assign sink      = (hold.key < best.key);
  assign sift_end  = ((state == hsk_pkg::ST_SIFT_CHK) && no_child) ||
                     ((state == hsk_pkg::ST_SIFT_CMP) && !sink);
  assign busy      = (state != hsk_pkg::ST_IDLE);

  // Where to go once the held element has found its place.
  always_comb begin
    if (build && (k > CNT_W'(1))) begin
      after_sift = hsk_pkg::ST_LOAD_NODE;
    end else if (size > CNT_W'(1)) begin
      after_sift = hsk_pkg::ST_EX_ROOT;
    end else begin
      after_sift = hsk_pkg::ST_IDLE;
    end
  end

  // Next state.
  always_comb begin
    unique case (state)
      hsk_pkg::ST_IDLE: begin
        state_next = (start && (start_size > CNT_W'(1))) ? hsk_pkg::ST_LOAD_NODE
                                                         : hsk_pkg::ST_IDLE;
      end
      hsk_pkg::ST_LOAD_NODE: state_next = hsk_pkg::ST_HOLD_CAP;
      hsk_pkg::ST_HOLD_CAP:  state_next = hsk_pkg::ST_SIFT_CHK;
      hsk_pkg::ST_SIFT_CHK:  state_next = no_child ? after_sift : hsk_pkg::ST_SIFT_L;
      hsk_pkg::ST_SIFT_L:    state_next = has_right ? hsk_pkg::ST_SIFT_R : hsk_pkg::ST_SIFT_CMP;
      hsk_pkg::ST_SIFT_R:    state_next = hsk_pkg::ST_SIFT_CMP;
      hsk_pkg::ST_SIFT_CMP:  state_next = sink ? hsk_pkg::ST_SIFT_CHK : after_sift;
      hsk_pkg::ST_EX_ROOT:   state_next = hsk_pkg::ST_EX_LAST;
      hsk_pkg::ST_EX_LAST:   state_next = hsk_pkg::ST_EX_SWAP;
      hsk_pkg::ST_EX_SWAP:   state_next = hsk_pkg::ST_SIFT_CHK;
      default:               state_next = hsk_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses of each state. A write and a read never share a cycle.
  always_comb begin
    mem_ctl = '0;
    wr_addr = node;
    wr_data = hold;
    rd_addr = child_w[ADDR_W-1:0];
    unique case (state)
      hsk_pkg::ST_LOAD_NODE: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = k_dec[ADDR_W-1:0];
      end
      hsk_pkg::ST_SIFT_CHK: begin
        mem_ctl.wr_en = no_child;
        mem_ctl.rd_en = !no_child;
      end
      hsk_pkg::ST_SIFT_L: begin
        mem_ctl.rd_en = has_right;
        rd_addr       = right_w[ADDR_W-1:0];
      end
      hsk_pkg::ST_SIFT_CMP: begin
        mem_ctl.wr_en = 1'b1;
        wr_data       = sink ? best : hold;
      end
      hsk_pkg::ST_EX_ROOT: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = '0;
      end
      hsk_pkg::ST_EX_LAST: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = size_dec[ADDR_W-1:0];
      end
      hsk_pkg::ST_EX_SWAP: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = size_dec[ADDR_W-1:0];
        wr_data       = best;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsk_pkg::ST_IDLE;
      build <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == hsk_pkg::ST_IDLE) && start) begin
        build <= 1'b1;
      end else if (sift_end && !(k > CNT_W'(1))) begin
        build <= 1'b0;
      end
    end
  end

  // Heap indices and the elements in flight.
  always_ff @(posedge clk) begin
    unique case (state)
      hsk_pkg::ST_IDLE: begin
        if (start) begin
          size <= start_size;
          k    <= start_size >> 1;
        end
      end
      hsk_pkg::ST_LOAD_NODE: node <= k_dec[ADDR_W-1:0];
      hsk_pkg::ST_HOLD_CAP:  hold <= rd_data;
      hsk_pkg::ST_SIFT_CHK:  pick <= child_w[ADDR_W-1:0];
      hsk_pkg::ST_SIFT_L:    best <= rd_data;
      hsk_pkg::ST_SIFT_R: begin
        // The right child wins only on a strictly larger key.
        if (best.key < rd_data.key) begin
          best <= rd_data;
          pick <= right_w[ADDR_W-1:0];
        end
      end
      hsk_pkg::ST_SIFT_CMP: begin
        if (sink) begin
          node <= pick;
        end
      end
      hsk_pkg::ST_EX_ROOT: begin
        node <= '0;
      end
      hsk_pkg::ST_EX_LAST: best <= rd_data;
      hsk_pkg::ST_EX_SWAP: begin
        hold <= rd_data;
        size <= size_dec;
        node <= '0;
      end
      default: begin
        node <= node;
      end
    endcase
    // Step the build counter down to the next inner node.
    if (sift_end && build && (k > CNT_W'(1))) begin
      k <= k_dec;
    end
  end

endmodule

[rtl/heap_sort_key_payload_core.sv]
// Top level of the heapsort key/payload engine.
// Depends on hsk_pkg, hsk_ram and hsk_sorter.
`timescale 1ns / 1ps

// Loads (mode 0) write one entry each into a single entry memory. The load marked last
// starts an in-place heapsort; the input stalls until it ends. Each sift level steps
// through SIFT_CHK, SIFT_L, SIFT_R when a right child exists, and SIFT_CMP on the
// one-read, one-write memory port. Reads (mode 1) return the entries in ascending key
// order, one transaction per read; the result passes the rd_pend register and is then
// registered at the output, and no new read is taken while one is pending. Loads are
// still taken while a result waits at the output. A read with no entry left, or before
// any sort, reports empty_res. Loads past MAX_ENTRIES are dropped and flagged by dropped
// until the next batch. The memory needs no clearing pass after reset.
module heap_sort_key_payload_core #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        mode,
  input  logic [63:0] sort_key,
  input  logic [15:0] position,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] out_position,
  output logic [63:0] out_key,
  output logic        final_res,
  output logic        empty_res,
  output logic        dropped
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] read_pointer;
  logic             overflow_seen;
  logic             sorted_phase;
  logic             rd_pend;
  logic             pend_empty;
  logic             pend_final;
  logic             pend_dropped;

  logic             item_accept;
  logic             load_acc;
  logic             read_acc;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] cnt_after;
  logic             has_room;
  logic             avail;

  logic              sort_busy;
  hsk_pkg::mem_ctl_t sort_ctl;
  logic [ADDR_W-1:0] sort_wr_addr;
  logic [ADDR_W-1:0] sort_rd_addr;
  hsk_pkg::entry_t   sort_wr_data;

  hsk_pkg::mem_ctl_t mem_ctl;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [ADDR_W-1:0] mem_rd_addr;
  hsk_pkg::entry_t   mem_wr_data;
  hsk_pkg::entry_t   mem_rd_data;

  // Input handshake. A read needs the output register free by the time its data arrives.
  assign item_stall  = sort_busy || rd_pend || (mode && res_valid && res_stall);
  assign item_accept = item_valid && !item_stall;
  assign load_acc    = item_accept && !mode;
  assign read_acc    = item_accept && mode;

  // The first load after a sort opens a new batch.
  assign cnt_eff   = sorted_phase ? '0 : entry_count;
  assign has_room  = (cnt_eff < CNT_W'(MAX_ENTRIES));
  assign cnt_after = has_room ? (cnt_eff + CNT_W'(1)) : cnt_eff;
  assign avail     = sorted_phase && (read_pointer < entry_count);

  // Memory port: the sorter owns it while busy, loads and reads use it otherwise.
  always_comb begin
    if (sort_busy) begin
      mem_ctl     = sort_ctl;
      mem_wr_addr = sort_wr_addr;
      mem_wr_data = sort_wr_data;
      mem_rd_addr = sort_rd_addr;
    end else begin
      mem_ctl.wr_en   = load_acc && has_room;
      mem_ctl.rd_en   = read_acc && avail;
      mem_wr_addr     = cnt_eff[ADDR_W-1:0];
      mem_wr_data.key = sort_key;
      mem_wr_data.pos = position;
      mem_rd_addr     = read_pointer[ADDR_W-1:0];
    end
  end

  hsk_ram #(
    .WIDTH (hsk_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  hsk_sorter #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .start      (load_acc && last),
    .start_size (cnt_after),
    .busy       (sort_busy),
    .mem_ctl    (sort_ctl),
    .wr_addr    (sort_wr_addr),
    .wr_data    (sort_wr_data),
    .rd_addr    (sort_rd_addr),
    .rd_data    (mem_rd_data)
  );

  // Batch bookkeeping and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      read_pointer  <= '0;
      overflow_seen <= 1'b0;
      sorted_phase  <= 1'b0;
      rd_pend       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (load_acc) begin
        entry_count   <= cnt_after;
        overflow_seen <= (overflow_seen && !sorted_phase) || !has_room;
        sorted_phase  <= last;
        if (sorted_phase || last) begin
          read_pointer <= '0;
        end
      end else if (read_acc && avail) begin
        read_pointer <= read_pointer + CNT_W'(1);
      end
      rd_pend <= read_acc;
      if (rd_pend) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: flags are taken at the read, the entry in the following cycle.
  always_ff @(posedge clk) begin
    if (read_acc) begin
      pend_empty   <= !avail;
      pend_final   <= ((read_pointer + CNT_W'(1)) == entry_count);
      pend_dropped <= overflow_seen;
    end
    if (rd_pend) begin
      out_key      <= pend_empty ? '0 : mem_rd_data.key;
      out_position <= pend_empty ? '0 : mem_rd_data.pos;
      final_res    <= !pend_empty && pend_final;
      empty_res    <= pend_empty;
      dropped      <= pend_dropped;
    end
  end

`ifndef ASSERT_OFF
  // A result is never loaded over one that still waits.
  assert property (@(posedge clk) disable iff (rst) rd_pend |-> !res_valid)
    else $error("result register overwritten");

  // Every accepted read raises res_valid once it has passed the rd_pend register.
  assert property (@(posedge clk) disable iff (rst) read_acc |=> ##1 res_valid)
    else $error("read transaction produced no result");

  // The read pointer never passes the number of held entries.
  assert property (@(posedge clk) disable iff (rst) read_pointer <= entry_count)
    else $error("read pointer beyond entry count");

  // A closing load with two or more entries keeps the sorter busy afterwards.
  assert property (@(posedge clk) disable iff (rst)
                   (load_acc && last && (cnt_after > CNT_W'(1))) |=> sort_busy)
    else $error("sort did not start");

  // The memory port never reads and writes in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("memory read and write collide");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the heapsort key/payload engine.
// Depends on hsk_pkg and heap_sort_key_payload_core; predicts untyped reads with its own heap sort.
`timescale 1ns / 1ps

module testbench;

  localparam int KEY_W        = hsk_pkg::KEY_W;
  localparam int POS_W        = hsk_pkg::POS_W;
  localparam int CAPACITY     = 1024;
  localparam int RANDOM_ITEMS = 1450;
  localparam int NUM_DIRECTED = 23;
  localparam int STALL_PCT    = 36;
  localparam int WATCHDOG_MAX = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // One result of a read transaction.
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic             final_res;
    logic             empty_res;
    logic             dropped;
  } read_res_t;

  // One input transaction; typed marks a row whose result is written out by hand.
  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    logic             last;
    logic             typed;
    read_res_t        res;
  } item_t;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_MSB = {1'b1, {(KEY_W-1){1'b0}}};
  localparam read_res_t NO_RES    = '{16'h0, 64'h0, 1'b0, 1'b0, 1'b0};
  localparam read_res_t EMPTY_RES = '{16'h0, 64'h0, 1'b0, 1'b1, 1'b0};

  // Directed rows: reset, loading, extremes, equal keys, single entry, exhausted reads.
  localparam item_t DIRECTED [NUM_DIRECTED] = '{
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1, EMPTY_RES},
    '{MODE_LOAD, 64'h0, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1, EMPTY_RES},
    '{MODE_LOAD, KEY_MAX, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{MODE_LOAD, KEY_MSB, 16'h1234, 1'b0, 1'b0, NO_RES},
    '{MODE_LOAD, 64'h1, 16'h8000, 1'b0, 1'b0, NO_RES},
    '{MODE_LOAD, KEY_MAX, 16'h0007, 1'b1, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1, '{16'h0000, 64'h0, 1'b0, 1'b0, 1'b0}},
    '{MODE_READ, KEY_MAX, 16'hFFFF, 1'b1, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, KEY_MAX, 16'hFFFF, 1'b1, 1'b1, EMPTY_RES},
    '{MODE_LOAD, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b1, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1,
      '{16'hAAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0}},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1, EMPTY_RES},
    '{MODE_LOAD, 64'h7, 16'h0001, 1'b0, 1'b0, NO_RES},
    '{MODE_LOAD, 64'h7, 16'h0002, 1'b0, 1'b0, NO_RES},
    '{MODE_LOAD, 64'h7, 16'h0003, 1'b1, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b0, NO_RES},
    '{MODE_READ, 64'h0, 16'h0, 1'b0, 1'b1, EMPTY_RES}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic             mode = MODE_LOAD;
  logic [KEY_W-1:0] sort_key = '0;
  logic [POS_W-1:0] position = '0;
  logic             last = 1'b0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [POS_W-1:0] out_position;
  logic [KEY_W-1:0] out_key;
  logic             final_res;
  logic             empty_res;
  logic             dropped;

  item_t     stimulus_q[$];
  read_res_t expected_reads[$];
  item_t     on_pins;
  int        next_item = 0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        calm;

  // Shadow copy of the engine: entry store, batch counters and phase.
  logic [KEY_W-1:0] shadow_key [CAPACITY];
  logic [POS_W-1:0] shadow_pos [CAPACITY];
  int unsigned      shadow_count = 0;
  int unsigned      shadow_rd = 0;
  bit               shadow_overflow = 1'b0;
  bit               shadow_sorted = 1'b0;

  heap_sort_key_payload_core #(
    .MAX_ENTRIES(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .sort_key(sort_key),
    .position(position),
    .last(last),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .out_position(out_position),
    .out_key(out_key),
    .final_res(final_res),
    .empty_res(empty_res),
    .dropped(dropped)
  );

  always #5 clk = ~clk;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] p;
    k = shadow_key[a];
    p = shadow_pos[a];
    shadow_key[a] = shadow_key[b];
    shadow_pos[a] = shadow_pos[b];
    shadow_key[b] = k;
    shadow_pos[b] = p;
  endfunction

  // Move a node down the max-heap until neither child has a larger key.
  function automatic void sift_down(int unsigned size, int unsigned node);
    int unsigned child;
    bit          done;
    done = 1'b0;
    while (!done) begin
      child = 2 * node + 1;
      if (child >= size) begin
        done = 1'b1;
      end else begin
        if (child + 1 < size && shadow_key[child] < shadow_key[child + 1])
          child = child + 1;
        if (!(shadow_key[node] < shadow_key[child])) begin
          done = 1'b1;
        end else begin
          swap_entries(node, child);
          node = child;
        end
      end
    end
  endfunction

  // In-place heapsort of the held entries into ascending key order.
  function automatic void heapsort_held(int unsigned size);
    int unsigned k;
    if (size >= 2) begin
      for (k = size / 2; k > 0; k--)
        sift_down(size, k - 1);
      while (size > 1) begin
        swap_entries(0, size - 1);
        size = size - 1;
        sift_down(size, 0);
      end
    end
  endfunction

  // Apply one accepted transaction to the shadow engine; returns 1 when a read result is due.
  function automatic bit sort_engine_step(item_t it, output read_res_t r);
    r = NO_RES;
    if (it.mode == MODE_LOAD) begin
      if (shadow_sorted) begin
        shadow_count = 0;
        shadow_rd = 0;
        shadow_overflow = 1'b0;
        shadow_sorted = 1'b0;
      end
      if (shadow_count < CAPACITY) begin
        shadow_key[shadow_count] = it.key;
        shadow_pos[shadow_count] = it.position;
        shadow_count = shadow_count + 1;
      end else begin
        shadow_overflow = 1'b1;
      end
      if (it.last) begin
        heapsort_held(shadow_count);
        shadow_rd = 0;
        shadow_sorted = 1'b1;
      end
      return 1'b0;
    end
    r.dropped = shadow_overflow;
    if (shadow_sorted && shadow_rd < shadow_count) begin
      r.position  = shadow_pos[shadow_rd];
      r.key       = shadow_key[shadow_rd];
      r.final_res = (shadow_rd + 1 == shadow_count);
      shadow_rd = shadow_rd + 1;
    end else begin
      r.empty_res = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void add_load(logic [KEY_W-1:0] k, logic [POS_W-1:0] p, logic l);
    stimulus_q.push_back('{MODE_LOAD, k, p, l, 1'b0, NO_RES});
  endfunction

  // Reads carry random content in the fields that the engine ignores.
  function automatic void add_read();
    stimulus_q.push_back('{MODE_READ, {$urandom, $urandom}, POS_W'($urandom), 1'($urandom),
                           1'b0, NO_RES});
  endfunction

  // Keys: a small pool when duplicates are wanted, otherwise extremes or full random.
  function automatic logic [KEY_W-1:0] pick_key(bit dup);
    int sel;
    sel = $urandom_range(0, 7);
    if (dup) begin
      case (sel % 4)
        0: return '0;
        1: return KEY_MAX;
        2: return 64'h8;
        default: return 64'h9;
      endcase
    end
    if (sel == 0) return ($urandom_range(0, 1) != 0) ? KEY_MAX : '0;
    return {$urandom, $urandom};
  endfunction

  function automatic bit gap_now();
    return !calm && ($urandom_range(0, 99) < STALL_PCT);
  endfunction

  // No idling on either side for a stretch of the random part.
  assign calm = (next_item >= 300) && (next_item < 560);

  // Build the whole stimulus: directed table first, then random batches.
  initial begin
    int  n;
    int  reads;
    int  sel;
    bit  dup;
    bit  big_done;
    big_done = 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++)
      stimulus_q.push_back(DIRECTED[i]);
    while (stimulus_q.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (!big_done && stimulus_q.size() >= 500) begin
        // A full store plus dropped loads; the last load is itself dropped and starts the sort.
        big_done = 1'b1;
        n = CAPACITY + 3;
        dup = 1'b0;
      end else if (sel < 60) begin
        n = $urandom_range(1, 8);
        dup = ($urandom_range(0, 3) == 0);
      end else if (sel < 90) begin
        n = $urandom_range(9, 24);
        dup = ($urandom_range(0, 3) == 0);
      end else begin
        n = $urandom_range(25, 64);
        dup = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        if (n <= 64 && $urandom_range(0, 19) == 0)
          add_read();
        add_load(pick_key(dup), POS_W'($urandom),
                 (i == n - 1) && (n > 64 || $urandom_range(0, 15) != 0));
      end
      // Mostly read the batch out and past its end; sometimes stop early.
      if (n > 64)
        reads = 40;
      else if ($urandom_range(0, 4) == 0)
        reads = $urandom_range(0, n);
      else
        reads = n + $urandom_range(0, 2);
      for (int i = 0; i < reads; i++)
        add_read();
    end
  end

  // Reset, then wait for the stimulus to drain and give the verdict.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (!(next_item == stimulus_q.size() && !item_valid))
      @(negedge clk);
    while (expected_reads.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_reads.size() == 0 && !res_valid) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Input side: model the accepted transaction, then present the next one or idle.
  always @(posedge clk) begin
    read_res_t predicted;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (sort_engine_step(on_pins, predicted))
          expected_reads.push_back(on_pins.typed ? on_pins.res : predicted);
      end
      if (!item_valid || !item_stall) begin
        if (next_item < stimulus_q.size() && !gap_now()) begin
          on_pins = stimulus_q[next_item];
          next_item = next_item + 1;
          mode       <= on_pins.mode;
          sort_key   <= on_pins.key;
          position   <= on_pins.position;
          last       <= on_pins.last;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stall.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= gap_now();
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    read_res_t want;
    read_res_t got;
    if (!rst && res_valid && !res_stall) begin
      got = '{out_position, out_key, final_res, empty_res, dropped};
      if (expected_reads.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected result pos=%h key=%h final=%b empty=%b dropped=%b",
                   $realtime, got.position, got.key, got.final_res, got.empty_res,
                   got.dropped);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_reads.pop_front();
        if (got !== want) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch pos=%h/%h key=%h/%h final=%b/%b empty=%b/%b dropped=%b/%b",
                     $realtime, want.position, got.position, want.key, got.key,
                     want.final_res, got.final_res, want.empty_res, got.empty_res,
                     want.dropped, got.dropped);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
